@@ sv/sitda_pkg.sv @@
// Package for the signed integer to decimal ASCII converter.
// Holds the shared item type, character constants and the back-end state type.
// No dependencies.
package sitda_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigitIdxW = $clog2(MaxDigits);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  // ASCII codes
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;

  // Reciprocal of ten: floor(x * Recip10 / 2^35) == x / 10 for every 32-bit x
  localparam logic [ValueW-1:0] Recip10 = 32'hCCCCCCCD;
  localparam int unsigned Recip10Shift = 35;

  // Classified item passed from front to back
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } sitda_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } sitda_state_t;

endpackage

@@ sv/sitda_front.sv @@
// Front end: accepts input transactions and splits them into sign and magnitude.
// Depends on sitda_pkg.
module sitda_front import sitda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [ValueW-1:0] value,
  output logic              item_valid,
  output sitda_item_t       item,
  input  logic              item_take
);

  logic        valid;
  sitda_item_t held;

  // Stage is free when empty or when its item moves on this cycle
  assign full       = valid && !item_take;
  assign item_valid = valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push && !full) begin
      valid <= 1'b1;
    end else if (item_take) begin
      valid <= 1'b0;
    end
  end

  // Magnitude taken as unsigned, so the most negative value comes out right
  always_ff @(posedge clk) begin
    if (push && !full) begin
      held.neg <= value[ValueW-1];
      held.mag <= value[ValueW-1] ? (~value + 32'd1) : value;
    end
  end

endmodule

@@ sv/sitda_queue.sv @@
// Short queue between front and back so that each side stalls on its own.
// Depends on sitda_pkg.
module sitda_queue import sitda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  sitda_item_t wr_item,
  output logic        q_full,
  input  logic        rd_en,
  output sitda_item_t rd_item,
  output logic        q_empty
);

  sitda_item_t               store [QueueDepth];
  logic [QueuePtrW-1:0]      wr_ptr;
  logic [QueuePtrW-1:0]      rd_ptr;
  logic [QueuePtrW:0]        count;

  assign q_full  = (count == (QueuePtrW+1)'(QueueDepth));
  assign q_empty = (count == '0);
  assign rd_item = store[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_item;
    end
  end

endmodule

@@ sv/sitda_back.sv @@
// Back end: extracts digits by repeated division by ten, then emits characters.
// Depends on sitda_pkg.
module sitda_back import sitda_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  sitda_item_t      q_item,
  output logic             q_take,
  output logic             empty,
  input  logic             pop,
  output logic [CharW-1:0] char_code,
  output logic             last
);

  sitda_state_t           state;
  sitda_state_t           state_next;
  logic [ValueW-1:0]      mag;
  logic                   neg;
  logic [DigitIdxW-1:0]   nd;
  logic [DigitIdxW-1:0]   idx;
  logic [3:0]             digits [MaxDigits];
  logic                   out_valid;
  logic                   out_free;
  logic [2*ValueW-1:0]    prod;
  logic [ValueW-1:0]      quot;
  logic [3:0]             rem;
  logic [3:0]             quot_x10_lo;
  logic                   conv_done;

  // Divide by ten through the reciprocal; only the low nibble of q*10 matters
  assign prod        = mag * Recip10;
  assign quot        = ValueW'(prod >> Recip10Shift);
  assign quot_x10_lo = {quot[2:0], 1'b0} + {quot[0], 3'b000};
  assign rem         = mag[3:0] - quot_x10_lo;
  assign conv_done   = (quot == '0) || (nd == DigitIdxW'(MaxDigits - 1));

  assign out_free = !out_valid || pop;
  assign empty    = out_valid ? 1'b0 : 1'b1;
  assign q_take   = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_next = neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free && (idx == '0)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath: load, divide step, emit index
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          mag <= q_item.mag;
          neg <= q_item.neg;
          nd  <= '0;
        end
      end
      ST_CONV: begin
        digits[nd] <= rem;
        mag        <= quot;
        nd         <= nd + 1'b1;
        idx        <= nd;
      end
      ST_DIGIT: begin
        if (out_free && (idx != '0)) begin
          idx <= idx - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_SIGN || state == ST_DIGIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == ST_SIGN) begin
        char_code <= ChMinus;
        last      <= 1'b0;
      end else if (state == ST_DIGIT) begin
        char_code <= ChZero + {4'd0, digits[idx]};
        last      <= (idx == '0);
      end
    end
  end

endmodule

@@ sv/signed_int_to_decimal_ascii_top.sv @@
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_front, sitda_queue and sitda_back.
//
// Usage:
//   Input channel: drive value and raise push; a transaction is taken at a
//   rising edge with push high and full low.
//   Result channel: while empty is low, char_code and last show the oldest
//   character; it is taken at a rising edge with pop high. Characters of one
//   number come most significant first, a '-' ahead of a negative value,
//   and last marks the final digit.
// Buffering and conversion:
//   The front register and a two-entry queue hold up to three numbers ahead
//   of the converter, so input is taken while results wait. The converter
//   works on one number at a time: it loads the number, extracts one decimal
//   digit per divide-by-ten step (a 32x32 reciprocal multiply), then emits
//   its characters, a minus first for a negative value, holding while the
//   output register is full and pop is low. It takes no new number from the
//   queue until the last character of the old one is in the output register.
// Reset: rst, synchronous, empties all stages; nothing is in flight after.
// Stall: while pop stays low the output register holds its character and
//   the back end waits; the queue then fills and full rises.
module signed_int_to_decimal_ascii_top import sitda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [ValueW-1:0] value,
  output logic              empty,
  input  logic              pop,
  output logic [CharW-1:0]  char_code,
  output logic              last
);

  logic        f_valid;
  sitda_item_t f_item;
  logic        f_take;
  logic        q_full;
  logic        q_empty;
  sitda_item_t q_item;
  logic        q_take;

  assign f_take = f_valid && !q_full;

  sitda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .item_valid (f_valid),
    .item       (f_item),
    .item_take  (f_take)
  );

  sitda_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_take),
    .wr_item (f_item),
    .q_full  (q_full),
    .rd_en   (q_take),
    .rd_item (q_item),
    .q_empty (q_empty)
  );

  sitda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_take    (q_take),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .last      (last)
  );

  // Every character shown is a minus or a decimal digit
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (char_code == ChMinus) || ((char_code >= ChZero) && (char_code <= ChNine)))
    else $error("character out of range");

  // A minus sign never ends a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (char_code == ChMinus)) |-> !last)
    else $error("minus flagged as last");

  // After a minus is taken, the next character shown is not another minus
  a_after_minus: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && (char_code == ChMinus)) |=> (empty || (char_code != ChMinus)))
    else $error("two minus signs in a row");

  // The queue is never written while full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !f_take)
    else $error("queue overflow");

endmodule
